// ===== design/spiral_scan_address_generator_assert.svh =====
// assertion macros used by the checker file
`ifndef SPIRAL_SCAN_ADDRESS_GENERATOR_ASSERT_SVH
`define SPIRAL_SCAN_ADDRESS_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSAG_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ssag check failed");

// next-cycle implication, checked outside reset
`define SSAG_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ssag check failed");

`endif

// ===== design/ssag_pkg.sv =====
// shared types, constants and helpers of the spiral scan address generator
`timescale 1ns / 1ps

package ssag_pkg;

    localparam int DEF_MAX_DIM = 1024;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 11;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;

    localparam logic [CFG_AW-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_AW-1:0] REG_START_ROW = 2'd2;
    localparam logic [CFG_AW-1:0] REG_START_COL = 2'd3;

    // signed coordinate width: rings reach about one grid size past either edge
    function automatic int coord_w(input int max_dim);
        int w;
        w = $clog2(max_dim) + 3;
        return (w > DIM_W + 2) ? w : DIM_W + 2;
    endfunction

    typedef struct packed {
        logic init;
        logic step;
        logic count_inc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic exhausted;
        logic in_grid;
    } t_dp_status;

endpackage

// ===== design/spiral_scan_address_generator.sv =====
// Spiral scan address generator: each request word returns the next grid cell of a clockwise
// spiral around the start cell (or the start cell again when restart is set), with a flag on
// the final cell and an exhausted flag once every cell was given. While a request
// is worked, the walk register steps along the ring, jumping over any out-of-grid stretch of
// a side at once. While the previous word is stalled at the output, the next one is not
// loaded. One request is worked at a time; a finished word waits in the output register
// while the next request is taken. A configuration write restarts the walk.
`timescale 1ns / 1ps

module spiral_scan_address_generator import ssag_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_restart,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_cell_row,
    output logic [POS_W-1:0]  o_cell_col,
    output logic              o_last_cell,
    output logic              o_exhausted
);

    localparam int CW = coord_w(MAX_DIM);
    localparam int PW = 2 * CW;

    logic signed [CW-1:0] rows;
    logic signed [CW-1:0] cols;
    logic signed [CW-1:0] row0;
    logic signed [CW-1:0] col0;
    logic [PW-1:0]        total;
    t_dp_cmd              dp_cmd;
    t_dp_status           dp_status;

    ssag_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_rows     (rows),
        .o_cols     (cols),
        .o_row0     (row0),
        .o_col0     (col0),
        .o_total    (total)
    );

    ssag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .i_restart   (i_restart),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    ssag_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rows      (rows),
        .i_cols      (cols),
        .i_row0      (row0),
        .i_col0      (col0),
        .i_total     (total),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_cell_row  (o_cell_row),
        .o_cell_col  (o_cell_col),
        .o_last_cell (o_last_cell),
        .o_exhausted (o_exhausted)
    );

endmodule

// ===== design/ssag_cfg.sv =====
// configuration registers, saturated grid settings and cell total
`timescale 1ns / 1ps

module ssag_cfg import ssag_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CW = coord_w(MAX_DIM),
    localparam int PW = 2 * CW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    output logic signed [CW-1:0] o_rows,
    output logic signed [CW-1:0] o_cols,
    output logic signed [CW-1:0] o_row0,
    output logic signed [CW-1:0] o_col0,
    output logic [PW-1:0]        o_total
);

    localparam logic [CW-1:0] MAX_U = CW'(MAX_DIM);

    logic [DIM_W-1:0] r_grid_rows;
    logic [DIM_W-1:0] r_grid_cols;
    logic [POS_W-1:0] r_start_row;
    logic [POS_W-1:0] r_start_col;
    logic [PW-1:0]    r_total;

    logic [CW-1:0] rows_raw;
    logic [CW-1:0] cols_raw;
    logic [CW-1:0] rows_u;
    logic [CW-1:0] cols_u;
    logic [CW-1:0] srow_u;
    logic [CW-1:0] scol_u;
    logic [CW-1:0] row0_u;
    logic [CW-1:0] col0_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_W'(1);
            r_grid_cols <= DIM_W'(1);
            r_start_row <= '0;
            r_start_col <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                REG_START_ROW: r_start_row <= i_cfg_data[POS_W-1:0];
                REG_START_COL: r_start_col <= i_cfg_data[POS_W-1:0];
            endcase
        end
    end

    always_comb begin
        rows_raw = CW'(r_grid_rows);
        cols_raw = CW'(r_grid_cols);
        srow_u   = CW'(r_start_row);
        scol_u   = CW'(r_start_col);
        rows_u   = (rows_raw == '0) ? CW'(1) : ((rows_raw > MAX_U) ? MAX_U : rows_raw);
        cols_u   = (cols_raw == '0) ? CW'(1) : ((cols_raw > MAX_U) ? MAX_U : cols_raw);
        row0_u   = (srow_u > rows_u - CW'(1)) ? rows_u - CW'(1) : srow_u;
        col0_u   = (scol_u > cols_u - CW'(1)) ? cols_u - CW'(1) : scol_u;
    end

    always_ff @(posedge i_clk) begin
        r_total <= rows_u * cols_u;
    end

    assign o_rows  = $signed(rows_u);
    assign o_cols  = $signed(cols_u);
    assign o_row0  = $signed(row0_u);
    assign o_col0  = $signed(col0_u);
    assign o_total = r_total;

endmodule

// ===== design/ssag_ctrl.sv =====
// handshake and sequencing controller of the spiral walk
`timescale 1ns / 1ps

module ssag_ctrl import ssag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_in_valid,
    input  logic       i_restart,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_stale;
    logic   n_stale;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_stale     = r_stale || i_cfg_we;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.init = i_restart || r_stale;
                    n_stale    = i_cfg_we;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                priority if (i_status.exhausted) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_status.in_grid) begin
                    if (out_free) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.step      = 1'b1;
                        o_cmd.count_inc = 1'b1;
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_stale     <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_stale     <= n_stale;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/ssag_dp.sv =====
// probe, ring bounds, cell count and output word of the spiral walk
`timescale 1ns / 1ps

module ssag_dp import ssag_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    localparam int CW = coord_w(MAX_DIM),
    localparam int PW = 2 * CW
) (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_rows,
    input  logic signed [CW-1:0] i_cols,
    input  logic signed [CW-1:0] i_row0,
    input  logic signed [CW-1:0] i_col0,
    input  logic [PW-1:0]        i_total,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic [POS_W-1:0]     o_cell_row,
    output logic [POS_W-1:0]     o_cell_col,
    output logic                 o_last_cell,
    output logic                 o_exhausted
);

    typedef enum logic [2:0] {
        SIDE_START,
        SIDE_EAST,
        SIDE_SOUTH_EAST,
        SIDE_SOUTH,
        SIDE_LEFT,
        SIDE_TOP,
        SIDE_RIGHT,
        SIDE_BOTTOM
    } t_side;

    logic signed [CW-1:0] r_prow, n_prow;
    logic signed [CW-1:0] r_pcol, n_pcol;
    logic signed [CW-1:0] r_top, n_top;
    logic signed [CW-1:0] r_bot, n_bot;
    logic signed [CW-1:0] r_left, n_left;
    logic signed [CW-1:0] r_right, n_right;
    t_side                r_side, n_side;
    logic [PW-1:0]        r_count;
    logic [POS_W-1:0]     r_cell_row;
    logic [POS_W-1:0]     r_cell_col;
    logic                 r_last;
    logic                 r_exh;

    logic row_ok;
    logic col_ok;
    logic in_grid;
    logic exhausted;

    assign row_ok    = !r_prow[CW-1] && (r_prow < i_rows);
    assign col_ok    = !r_pcol[CW-1] && (r_pcol < i_cols);
    assign in_grid   = row_ok && col_ok;
    assign exhausted = (r_count >= i_total);

    // one probe step; out-of-grid stretches of a side are skipped at once
    always_comb begin
        n_prow  = r_prow;
        n_pcol  = r_pcol;
        n_top   = r_top;
        n_bot   = r_bot;
        n_left  = r_left;
        n_right = r_right;
        n_side  = r_side;
        unique case (r_side)
            SIDE_START: begin
                n_side = SIDE_EAST;
                n_prow = r_top;
                n_pcol = r_right;
            end
            SIDE_EAST: begin
                n_side = SIDE_SOUTH_EAST;
                n_prow = r_bot;
                n_pcol = r_right;
            end
            SIDE_SOUTH_EAST: begin
                n_side = SIDE_SOUTH;
                n_prow = r_bot;
                n_pcol = r_left;
            end
            SIDE_SOUTH: begin
                n_side  = SIDE_LEFT;
                n_top   = r_top - CW'(1);
                n_left  = r_left - CW'(1);
                n_bot   = r_bot + CW'(1);
                n_right = r_right + CW'(1);
                n_prow  = r_bot;
                n_pcol  = r_left - CW'(1);
            end
            SIDE_LEFT: begin
                if (in_grid && (r_prow > r_top)) begin
                    n_prow = r_prow - CW'(1);
                end else if (in_grid || !col_ok || r_prow[CW-1]) begin
                    n_side = SIDE_TOP;
                    n_prow = r_top;
                    n_pcol = r_left + CW'(1);
                end else begin
                    n_prow = i_rows - CW'(1);
                end
            end
            SIDE_TOP: begin
                if (in_grid && (r_pcol < r_right)) begin
                    n_pcol = r_pcol + CW'(1);
                end else if (in_grid || !row_ok || (r_pcol >= i_cols)) begin
                    n_side = SIDE_RIGHT;
                    n_prow = r_top + CW'(1);
                    n_pcol = r_right;
                end else begin
                    n_pcol = '0;
                end
            end
            SIDE_RIGHT: begin
                if (in_grid && (r_prow < r_bot)) begin
                    n_prow = r_prow + CW'(1);
                end else if (in_grid || !col_ok || (r_prow >= i_rows)) begin
                    n_side = SIDE_BOTTOM;
                    n_prow = r_bot;
                    n_pcol = r_right - CW'(1);
                end else begin
                    n_prow = '0;
                end
            end
            SIDE_BOTTOM: begin
                if (in_grid && (r_pcol > r_left)) begin
                    n_pcol = r_pcol - CW'(1);
                end else if (in_grid || !row_ok || r_pcol[CW-1]) begin
                    n_side  = SIDE_LEFT;
                    n_top   = r_top - CW'(1);
                    n_left  = r_left - CW'(1);
                    n_bot   = r_bot + CW'(1);
                    n_right = r_right + CW'(1);
                    n_prow  = r_bot;
                    n_pcol  = r_left - CW'(1);
                end else begin
                    n_pcol = i_cols - CW'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_prow  <= i_row0;
            r_pcol  <= i_col0;
            r_top   <= i_row0;
            r_bot   <= i_row0 + CW'(1);
            r_left  <= i_col0;
            r_right <= i_col0 + CW'(1);
            r_side  <= SIDE_START;
            r_count <= '0;
        end else begin
            if (i_cmd.step) begin
                r_prow  <= n_prow;
                r_pcol  <= n_pcol;
                r_top   <= n_top;
                r_bot   <= n_bot;
                r_left  <= n_left;
                r_right <= n_right;
                r_side  <= n_side;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (exhausted) begin
                r_cell_row <= '0;
                r_cell_col <= '0;
                r_last     <= 1'b0;
                r_exh      <= 1'b1;
            end else begin
                r_cell_row <= r_prow[POS_W-1:0];
                r_cell_col <= r_pcol[POS_W-1:0];
                r_last     <= ((r_count + PW'(1)) == i_total);
                r_exh      <= 1'b0;
            end
        end
    end

    assign o_status.exhausted = exhausted;
    assign o_status.in_grid   = in_grid;
    assign o_cell_row         = r_cell_row;
    assign o_cell_col         = r_cell_col;
    assign o_last_cell        = r_last;
    assign o_exhausted        = r_exh;

endmodule

// ===== design/ssag_checker.sv =====
// port-level checks of the spiral scan address generator and their binding
`timescale 1ns / 1ps
`include "spiral_scan_address_generator_assert.svh"

module ssag_checker import ssag_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [POS_W-1:0]  o_cell_row,
    input logic [POS_W-1:0]  o_cell_col,
    input logic              o_last_cell,
    input logic              o_exhausted
);

    logic [2*POS_W+1:0] out_word;

    assign out_word = {o_cell_row, o_cell_col, o_last_cell, o_exhausted};

    // an exhausted word carries no cell and is never the final cell
    `SSAG_ASSERT_SAME(a_exh_word, o_out_valid && o_exhausted, out_word[2*POS_W+1:1] == '0)

    // a taken request makes the block busy in the next cycle
    `SSAG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a new word only appears after the block was working on a request
    `SSAG_ASSERT_SAME(a_word_from_request, $rose(o_out_valid), $past(o_in_stall))

    // a stalled word holds
    `SSAG_ASSERT_NEXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))

endmodule

bind spiral_scan_address_generator ssag_checker u_ssag_checker (.*);
